FILE: hdl/mmp_pkg.sv
// shared types, constants and address helpers of the min/max pyramid builder
package mmp_pkg;

    localparam int LOG_RES         = 8;
    localparam int SAMPLE_BITS     = 32;
    localparam int MAX_DEPTH_FIELD = 7;

    localparam int NUM_LEVELS  = LOG_RES - 1;
    localparam int COORD_W     = LOG_RES - 1;
    localparam int COUNT_W     = LOG_RES + 1;
    localparam int STORE_DEPTH = ((1 << (2 * LOG_RES)) - 4) / 3;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WORD_W      = 2 * SAMPLE_BITS;
    localparam int LVL_W       = $clog2(NUM_LEVELS + 1);
    localparam int QMAX        = (MAX_DEPTH_FIELD < NUM_LEVELS) ? MAX_DEPTH_FIELD : NUM_LEVELS;

    localparam int KIND_W   = 2;
    localparam int PATH_W   = 14;
    localparam int DEPTH_W  = 3;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = ((SAMPLE_BITS + PATH_W + DEPTH_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((WORD_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_ANSWER  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SUMMARY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic signed [SAMPLE_BITS-1:0] max_v;
        logic signed [SAMPLE_BITS-1:0] min_v;
    } res_t;

    // first store address of a level, levels laid out from the finest up
    function automatic logic [ADDR_W-1:0] level_offset(input int lvl);
        logic [ADDR_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < NUM_LEVELS; j++) begin
            if (j < lvl) begin
                acc = acc + (ADDR_W'(1) << (2 * (LOG_RES - 1 - j)));
            end
        end
        return acc;
    endfunction

endpackage

FILE: hdl/mmp_ram.sv
// simple dual-port ram with registered read data
module mmp_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/mmp_res_queue.sv
// two-entry result buffer: output register plus one holding slot
module mmp_res_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mmp_pkg::res_t push_data,
    input  logic          m_tready,
    output logic          m_tvalid,
    output mmp_pkg::res_t out_data,
    output logic          full
);

    logic          out_v_reg, out_v_next;
    logic          hold_v_reg, hold_v_next;
    mmp_pkg::res_t out_reg, out_next;
    mmp_pkg::res_t hold_reg, hold_next;
    logic          pop;

    assign pop      = out_v_reg && m_tready;
    assign m_tvalid = out_v_reg;
    assign out_data = out_reg;
    assign full     = hold_v_reg;

    always_comb begin
        out_v_next  = out_v_reg;
        hold_v_next = hold_v_reg;
        out_next    = out_reg;
        hold_next   = hold_reg;
        if (pop || !out_v_reg) begin
            if (hold_v_reg) begin
                out_next    = hold_reg;
                out_v_next  = 1'b1;
                hold_next   = push_data;
                hold_v_next = push;
            end else begin
                out_next   = push_data;
                out_v_next = push;
            end
        end else if (push) begin
            hold_next   = push_data;
            hold_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

endmodule

FILE: hdl/min_max_pyramid_builder.sv
// top level of the min/max pyramid builder
//
// usage: s_ carries one transaction per item, s_tuser is the kind (sample, query,
// clear), s_tdata packs sample_value, quadrant_path and path_depth. m_ carries
// results: m_tdata packs min_value and max_value, m_tuser is the status.
// samples arrive in raster order over a (2^LOG_RES+1)-square tile; the block counts
// column and row itself and keeps every pyramid level in one shared cell ram
// holding {max, min} words.
// a sample does one read-modify-write per level through the single ram read port,
// the write following in the cycle after the read.
// the last sample of a tile pushes the tile summary into the result buffer when its
// transaction is taken. a query passes through address capture, ram read and result
// states; a query with a bad depth pushes its answer when its transaction is taken.
// after reset and after each clear item the ram is swept to its initial values over
// all STORE_DEPTH = (4^LOG_RES - 4)/3 cells (21844), with s_tready low meanwhile.
// results go through an output register and one holding slot, so an item is still
// taken while a result waits; s_tready drops when both are full or outside idle.
module min_max_pyramid_builder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata from bit 0: sample_value, quadrant_path, path_depth, zero pad
    input  logic [mmp_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: kind
    input  logic [mmp_pkg::KIND_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata from bit 0: min_value, max_value, zero pad
    output logic [mmp_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: status
    output logic [mmp_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int SB = mmp_pkg::SAMPLE_BITS;
    localparam int AW = mmp_pkg::ADDR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_QRD  = 3'd2;
    localparam logic [2:0] ST_QWT  = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [mmp_pkg::LVL_W-1:0]   lvl_reg, lvl_next;
    logic [mmp_pkg::COUNT_W-1:0] col_reg, col_next;
    logic [mmp_pkg::COUNT_W-1:0] row_reg, row_next;
    logic signed [SB-1:0]        tile_min_reg, tile_min_next;
    logic signed [SB-1:0]        tile_max_reg, tile_max_next;
    logic                        upd_rd_reg, upd_rd_next;
    logic [AW-1:0]               clr_cnt_reg, clr_cnt_next;

    // payload registers
    logic signed [SB-1:0]         sample_reg;
    logic [mmp_pkg::COORD_W-1:0]  cx_reg, cy_reg;
    logic [AW-1:0]                wb_addr_reg;
    logic [AW-1:0]                q_addr_reg;

    // input fields
    logic [mmp_pkg::KIND_W-1:0]  in_kind;
    logic signed [SB-1:0]        in_sample;
    logic [mmp_pkg::PATH_W-1:0]  in_path;
    logic [mmp_pkg::DEPTH_W-1:0] in_depth;

    assign in_kind   = s_tuser;
    assign in_sample = s_tdata[SB-1:0];
    assign in_path   = s_tdata[SB+mmp_pkg::PATH_W-1:SB];
    assign in_depth  = s_tdata[SB+mmp_pkg::PATH_W+mmp_pkg::DEPTH_W-1:SB+mmp_pkg::PATH_W];

    logic accept, q_full;
    assign s_tready = (state_reg == ST_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;

    // cell coordinates on level 0; the last odd row and column fold into the last cell
    logic [mmp_pkg::COORD_W-1:0] cx_new, cy_new;
    assign cx_new = col_reg[mmp_pkg::LOG_RES] ? '1 : col_reg[mmp_pkg::LOG_RES-1:1];
    assign cy_new = row_reg[mmp_pkg::LOG_RES] ? '1 : row_reg[mmp_pkg::LOG_RES-1:1];

    // running tile extremes including the incoming sample
    logic signed [SB-1:0] tmin_upd, tmax_upd;
    assign tmin_upd = (in_sample < tile_min_reg) ? in_sample : tile_min_reg;
    assign tmax_upd = (in_sample > tile_max_reg) ? in_sample : tile_max_reg;

    logic last_sample;
    assign last_sample = col_reg[mmp_pkg::LOG_RES] && row_reg[mmp_pkg::LOG_RES];

    // cell address of the current level during the update sweep
    logic [AW-1:0] upd_addr;
    always_comb begin
        upd_addr = '0;
        for (int k = 0; k < mmp_pkg::NUM_LEVELS; k++) begin
            if (lvl_reg == mmp_pkg::LVL_W'(k)) begin
                upd_addr = mmp_pkg::level_offset(k)
                         + (AW'(cy_reg >> k) << (mmp_pkg::LOG_RES - 1 - k))
                         + AW'(cx_reg >> k);
            end
        end
    end

    // quadrant path to cell address: x from the low bit of each pair, y from the high
    logic [mmp_pkg::QMAX-1:0] qx_full, qy_full;
    logic [AW-1:0]            q_addr;
    logic                     q_ok;
    always_comb begin
        for (int j = 0; j < mmp_pkg::QMAX; j++) begin
            qx_full[j] = in_path[2*j];
            qy_full[j] = in_path[2*j+1];
        end
        q_addr = '0;
        for (int d = 1; d <= mmp_pkg::QMAX; d++) begin
            if (int'(in_depth) == d) begin
                q_addr = mmp_pkg::level_offset(mmp_pkg::NUM_LEVELS - d)
                       + (AW'(qy_full & ((mmp_pkg::QMAX'(1) << d) - mmp_pkg::QMAX'(1))) << d)
                       + AW'(qx_full & ((mmp_pkg::QMAX'(1) << d) - mmp_pkg::QMAX'(1)));
            end
        end
    end
    assign q_ok = (in_depth != '0) && (int'(in_depth) <= mmp_pkg::QMAX);

    // cell ram
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [mmp_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;
    logic signed [SB-1:0]        rd_min, rd_max, mg_min, mg_max;

    assign rd_min = ram_rdata[SB-1:0];
    assign rd_max = ram_rdata[2*SB-1:SB];
    assign mg_min = (sample_reg < rd_min) ? sample_reg : rd_min;
    assign mg_max = (sample_reg > rd_max) ? sample_reg : rd_max;

    mmp_ram #(
        .DEPTH  (mmp_pkg::STORE_DEPTH),
        .ADDR_W (AW),
        .DATA_W (mmp_pkg::WORD_W)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result buffer
    logic          push;
    mmp_pkg::res_t push_data, out_data;

    mmp_res_queue u_res_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_data  (out_data),
        .full      (q_full)
    );

    assign m_tdata = mmp_pkg::OUT_DATA_W'({out_data.max_v, out_data.min_v});
    assign m_tuser = out_data.status;

    // control
    always_comb begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        tile_min_next = tile_min_reg;
        tile_max_next = tile_max_reg;
        upd_rd_next   = 1'b0;
        clr_cnt_next  = clr_cnt_reg;
        push          = 1'b0;
        push_data     = '0;
        ram_re        = 1'b0;
        ram_raddr     = upd_addr;
        ram_we        = 1'b0;
        ram_waddr     = clr_cnt_reg;
        ram_wdata     = {mmp_pkg::MOST_NEG, mmp_pkg::MOST_POS};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_kind)
                        mmp_pkg::KIND_SAMPLE: begin
                            tile_min_next = tmin_upd;
                            tile_max_next = tmax_upd;
                            if (col_reg[mmp_pkg::LOG_RES]) begin
                                col_next = '0;
                                row_next = row_reg[mmp_pkg::LOG_RES] ? '0 : row_reg + 1'b1;
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                            if (last_sample) begin
                                push             = 1'b1;
                                push_data.min_v  = tmin_upd;
                                push_data.max_v  = tmax_upd;
                                push_data.status = mmp_pkg::STATUS_SUMMARY;
                            end
                            lvl_next   = '0;
                            state_next = ST_UPD;
                        end
                        mmp_pkg::KIND_QUERY: begin
                            if (q_ok) begin
                                state_next = ST_QRD;
                            end else begin
                                push             = 1'b1;
                                push_data.status = mmp_pkg::STATUS_INVALID;
                            end
                        end
                        mmp_pkg::KIND_CLEAR: begin
                            col_next      = '0;
                            row_next      = '0;
                            tile_min_next = mmp_pkg::MOST_POS;
                            tile_max_next = mmp_pkg::MOST_NEG;
                            clr_cnt_next  = '0;
                            state_next    = ST_CLR;
                        end
                        default: begin
                            // unused kind, dropped
                        end
                    endcase
                end
            end
            ST_UPD: begin
                // one level read per cycle, finest level first
                ram_re      = 1'b1;
                ram_raddr   = upd_addr;
                upd_rd_next = 1'b1;
                if (lvl_reg == mmp_pkg::LVL_W'(mmp_pkg::NUM_LEVELS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_QRD: begin
                ram_re     = 1'b1;
                ram_raddr  = q_addr_reg;
                state_next = ST_QWT;
            end
            ST_QWT: begin
                push             = 1'b1;
                push_data.min_v  = rd_min;
                push_data.max_v  = rd_max;
                push_data.status = mmp_pkg::STATUS_ANSWER;
                state_next       = ST_IDLE;
            end
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(mmp_pkg::STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // write-back of the merged cell, in the cycle after its read
        if (upd_rd_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wb_addr_reg;
            ram_wdata = {mg_max, mg_min};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            lvl_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            tile_min_reg <= mmp_pkg::MOST_POS;
            tile_max_reg <= mmp_pkg::MOST_NEG;
            upd_rd_reg   <= 1'b0;
            clr_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            lvl_reg      <= lvl_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            tile_min_reg <= tile_min_next;
            tile_max_reg <= tile_max_next;
            upd_rd_reg   <= upd_rd_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= in_sample;
            cx_reg     <= cx_new;
            cy_reg     <= cy_new;
            q_addr_reg <= q_addr;
        end
        if (state_reg == ST_UPD) begin
            wb_addr_reg <= upd_addr;
        end
    end

endmodule

FILE: tb/tb.sv
// testbench of the min/max pyramid builder: directed table followed by random traffic
`timescale 1ns / 100ps

module tb;
    import mmp_pkg::*;

    localparam int TILE_RES     = (1 << LOG_RES) + 1;
    localparam int HALF_SIDE    = 1 << (LOG_RES - 1);
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 40;

    // kind 3 is not decoded by the block
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // even path bits carry x, odd bits y
    localparam logic [PATH_W-1:0] X_BITS_ONLY = 14'h1555;

    typedef logic signed [SAMPLE_BITS-1:0] height_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        height_t            value;
        logic [PATH_W-1:0]  path;
        logic [DEPTH_W-1:0] depth;
        logic               typed;   // answer given in the row instead of predicted
        res_t               answer;
    } dir_row_t;

    // answer fields in order: status, max, min
    localparam dir_row_t DIRECTED_ROWS [24] = '{
        // fresh out of reset every cell is empty
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd1, 1'b1, '{STATUS_ANSWER, MOST_NEG, MOST_POS}},
        // depth zero never addresses a cell
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd0, 1'b1, '{STATUS_INVALID, 32'sd0, 32'sd0}},
        '{KIND_QUERY,  -32'sd1,  14'h3FFF, 3'd0, 1'b1, '{STATUS_INVALID, 32'sd0, 32'sd0}},
        // unused kind with every data bit set, dropped silently
        '{KIND_UNUSED, -32'sd1,  14'h3FFF, 3'd7, 1'b0, '0},
        // extremes along the first row
        '{KIND_SAMPLE, MOST_NEG, 14'h0000, 3'd0, 1'b0, '0},
        '{KIND_SAMPLE, MOST_POS, 14'h3FFF, 3'd7, 1'b0, '0},
        '{KIND_SAMPLE, 32'sd0,   14'h0000, 3'd0, 1'b0, '0},
        '{KIND_SAMPLE, -32'sd1,  14'h0000, 3'd0, 1'b0, '0},
        '{KIND_SAMPLE, 32'sd5,   14'h0000, 3'd0, 1'b0, '0},
        // finest cells that just got data
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd7, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0001, 3'd7, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0004, 3'd7, 1'b0, '0},
        // far corner is still untouched
        '{KIND_QUERY,  32'sd0,   14'h3FFF, 3'd7, 1'b1, '{STATUS_ANSWER, MOST_NEG, MOST_POS}},
        // coarser levels over the corner at the origin
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd6, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd5, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd4, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd3, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd2, 1'b0, '0},
        // path bits above the depth are don't-care
        '{KIND_QUERY,  32'sd0,   14'h3FFC, 3'd1, 1'b0, '0},
        '{KIND_CLEAR,  32'sd0,   14'h0000, 3'd0, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd3, 1'b1, '{STATUS_ANSWER, MOST_NEG, MOST_POS}},
        '{KIND_SAMPLE, 32'sd12345, 14'h0000, 3'd0, 1'b0, '0},
        '{KIND_QUERY,  32'sd0,   14'h0000, 3'd7, 1'b0, '0},
        '{KIND_CLEAR,  -32'sd1,  14'h3FFF, 3'd7, 1'b0, '0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // pyramid copy kept by the testbench
    height_t cell_lo [STORE_DEPTH];
    height_t cell_hi [STORE_DEPTH];
    int      level_base [NUM_LEVELS];
    int      col_count;
    int      row_count;
    height_t tile_lo;
    height_t tile_hi;

    res_t pending_answers [$];
    int   fail_count = 0;

    // sender idling: stretches of random gaps and stretches with none
    int calm_share = 30;
    int send_stretch = 0;
    bit send_calm = 1'b0;

    min_max_pyramid_builder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic void clear_pyramid();
        for (int k = 0; k < STORE_DEPTH; k++) begin
            cell_lo[k] = MOST_POS;
            cell_hi[k] = MOST_NEG;
        end
        col_count = 0;
        row_count = 0;
        tile_lo   = MOST_POS;
        tile_hi   = MOST_NEG;
    endfunction

    // apply one transaction to the pyramid copy; returns 1 when it produces an answer
    function automatic bit pyramid_step(input logic [KIND_W-1:0] kind, input height_t value,
                                        input logic [PATH_W-1:0] path,
                                        input logic [DEPTH_W-1:0] depth, output res_t answer);
        int cx;
        int cy;
        int idx;
        int qx;
        int qy;
        answer = '0;
        case (kind)
            KIND_CLEAR: begin
                clear_pyramid();
                return 1'b0;
            end
            KIND_SAMPLE: begin
                // the last odd row and column fold into the last cell
                cx = ((col_count >> 1) > HALF_SIDE - 1) ? HALF_SIDE - 1 : (col_count >> 1);
                cy = ((row_count >> 1) > HALF_SIDE - 1) ? HALF_SIDE - 1 : (row_count >> 1);
                if (value < tile_lo) tile_lo = value;
                if (value > tile_hi) tile_hi = value;
                for (int l = 0; l < NUM_LEVELS; l++) begin
                    idx = level_base[l] + (cy >> l) * (HALF_SIDE >> l) + (cx >> l);
                    if (value < cell_lo[idx]) cell_lo[idx] = value;
                    if (value > cell_hi[idx]) cell_hi[idx] = value;
                end
                if (col_count == TILE_RES - 1 && row_count == TILE_RES - 1) begin
                    // counters wrap, further samples merge into the same tile
                    col_count      = 0;
                    row_count      = 0;
                    answer.status  = STATUS_SUMMARY;
                    answer.min_v   = tile_lo;
                    answer.max_v   = tile_hi;
                    return 1'b1;
                end
                if (col_count == TILE_RES - 1) begin
                    col_count = 0;
                    row_count++;
                end else begin
                    col_count++;
                end
                return 1'b0;
            end
            KIND_QUERY: begin
                if (depth == 0 || depth > QMAX) begin
                    answer.status = STATUS_INVALID;
                    return 1'b1;
                end
                qx = 0;
                qy = 0;
                for (int b = 0; b < depth; b++) begin
                    if (path[2 * b])     qx += 1 << b;
                    if (path[2 * b + 1]) qy += 1 << b;
                end
                idx = level_base[NUM_LEVELS - depth] + qy * (1 << depth) + qx;
                answer.status = STATUS_ANSWER;
                answer.min_v  = cell_lo[idx];
                answer.max_v  = cell_hi[idx];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic height_t random_height();
        case ($urandom_range(0, 9))
            0: return MOST_POS;
            1: return MOST_NEG;
            2, 3: return height_t'($urandom_range(0, 200)) - 100;
            default: return height_t'($urandom);
        endcase
    endfunction

    // one input transaction; the answer is predicted unless the caller types it in
    task automatic send_item(input logic [KIND_W-1:0] kind, input height_t value,
                             input logic [PATH_W-1:0] path, input logic [DEPTH_W-1:0] depth,
                             input bit typed, input res_t typed_answer);
        int   gap;
        bit   answers;
        res_t predicted;
        if (send_stretch == 0) begin
            send_calm    = ($urandom_range(0, 99) < calm_share);
            send_stretch = $urandom_range(8, 64);
        end
        send_stretch--;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_DATA_W'({depth, path, value});
        do @(posedge aclk); while (!s_tready);
        answers = pyramid_step(kind, value, path, depth, predicted);
        if (answers) pending_answers.push_back(typed ? typed_answer : predicted);
    endtask

    task automatic send_random(input logic [KIND_W-1:0] kind);
        logic [PATH_W-1:0]  path;
        logic [DEPTH_W-1:0] depth;
        path  = PATH_W'($urandom);
        depth = DEPTH_W'($urandom);
        // only the first rows ever hold data, so half the queries stay on row zero
        if (kind == KIND_QUERY && $urandom_range(0, 1) == 0) path &= X_BITS_ONLY;
        send_item(kind, random_height(), path, depth, 1'b0, '0);
    endtask

    initial begin : stimulus
        int pick;
        level_base[0] = 0;
        for (int l = 1; l < NUM_LEVELS; l++) begin
            level_base[l] = level_base[l - 1] + (HALF_SIDE >> (l - 1)) * (HALF_SIDE >> (l - 1));
        end
        clear_pyramid();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_SAMPLE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].path,
                      DIRECTED_ROWS[i].depth, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].answer);
        end

        // mixed traffic on a partly built pyramid, rare clears start anew
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 999);
            if (pick < 3) begin
                send_random(KIND_CLEAR);
            end else if (pick < 30) begin
                send_random(KIND_UNUSED);
            end else if (pick < 350) begin
                send_random(KIND_QUERY);
            end else begin
                send_random(KIND_SAMPLE);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int   stall;
        int   stretch;
        bit   calm;
        res_t got;
        res_t want;
        stretch = 0;
        calm    = 1'b0;
        m_tready <= 1'b0;
        repeat (2) @(posedge aclk);
        forever begin
            if (stretch == 0) begin
                calm    = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(4, 32);
            end
            stretch--;
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.min_v  = m_tdata[SAMPLE_BITS-1:0];
            got.max_v  = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            got.status = m_tuser;
            if (pending_answers.size() == 0) begin
                $error("result transaction with nothing expected: min %0d max %0d status %0d",
                       got.min_v, got.max_v, got.status);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.min_v !== want.min_v) begin
                    $error("min_value expected %0d actual %0d", want.min_v, got.min_v);
                    fail_count++;
                end
                if (got.max_v !== want.max_v) begin
                    $error("max_value expected %0d actual %0d", want.max_v, got.max_v);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
